// ----- rtl/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg: shared constants for the process table scheduler
// Command, life state and status codes, and the fixed id width.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

  localparam int ID_W = 31;

  localparam logic [3:0] CMD_ALLOC    = 4'd0;
  localparam logic [3:0] CMD_FREE     = 4'd1;
  localparam logic [3:0] CMD_RUNNABLE = 4'd2;
  localparam logic [3:0] CMD_SLEEP    = 4'd3;
  localparam logic [3:0] CMD_WAKEUP   = 4'd4;
  localparam logic [3:0] CMD_KILL     = 4'd5;
  localparam logic [3:0] CMD_EXIT     = 4'd6;
  localparam logic [3:0] CMD_WAIT     = 4'd7;
  localparam logic [3:0] CMD_YIELD    = 4'd8;
  localparam logic [3:0] CMD_SCHED    = 4'd9;

  localparam logic [2:0] LS_UNUSED   = 3'd0;
  localparam logic [2:0] LS_EMBRYO   = 3'd1;
  localparam logic [2:0] LS_SLEEPING = 3'd2;
  localparam logic [2:0] LS_RUNNABLE = 3'd3;
  localparam logic [2:0] LS_RUNNING  = 3'd4;
  localparam logic [2:0] LS_ZOMBIE   = 3'd5;

  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_FAIL    = 2'd1;
  localparam logic [1:0] STS_SLEPT   = 2'd2;
  localparam logic [1:0] STS_REFUSED = 2'd3;

  localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

endpackage

`default_nettype wire

// ----- rtl/pts_mem.sv -----
// ----------------------------------------------------------------------------
// pts_mem: process table storage
// One write and one registered read port; entries never written read as the
// reset word. A write and a read of the same entry in one cycle forward.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_mem #(
  parameter int W = 8,
  parameter int DEPTH = 64,
  parameter int AW = 6,
  parameter logic [W-1:0] RESET_WORD = '0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0]     mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [W-1:0]     rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && waddr == raddr) begin
      rdata_r <= wdata;
    end else if (vld_r[raddr]) begin
      rdata_r <= mem[raddr];
    end else begin
      rdata_r <= RESET_WORD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/process_table_scheduler.sv -----
// ----------------------------------------------------------------------------
// process_table_scheduler: round-robin process table with sleep and wakeup
// Sequencer over one table memory; scans read, modify and write one slot a
// cycle.
// ----------------------------------------------------------------------------
//  channel | ports                                     | transfer
//  in      | in_valid/in_ready, command, slot, ...     | one command
//  out     | out_valid/out_ready, status, slot, pid    | one result
//  cfg     | cfg_valid/cfg_ready, cfg_init_slot        | init slot write
//
// Free and unknown commands finish without a memory read; single-slot commands
// read their slot first; alloc, wakeup, kill, sched and wait scan the table; exit
// runs up to three scans. The memory's single read port, one slot a cycle,
// paces the scans.
// Reset clears the table through per-slot valid bits; no clearing pass.
// A result waits in the output register; the next command is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module process_table_scheduler #(
  parameter int SLOTS = 64,
  parameter int CHAN_BITS = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [3:0]               in_command,
  input  wire logic [5:0]               in_slot,
  input  wire logic [5:0]               in_parent_slot,
  input  wire logic                     in_has_parent,
  input  wire logic [31:0]              in_chan,
  input  wire logic [pts_pkg::ID_W-1:0] in_target_pid,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [1:0]                    out_status,
  output logic [5:0]                    out_slot,
  output logic [pts_pkg::ID_W-1:0]      out_pid,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [5:0]               cfg_init_slot
);
  import pts_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = SW + 1;
  localparam int AW2 = SW + 2;
  localparam int PW = SW + 1;
  localparam int L_LO = 0;
  localparam int P_LO = 3;
  localparam int R_LO = P_LO + ID_W;
  localparam int K_B = R_LO + PW;
  localparam int T_B = K_B + 1;
  localparam int C_LO = T_B + 1;
  localparam int EW = C_LO + CHAN_BITS;
  localparam logic [PW-1:0] NO_PAR = {1'b1, {SW{1'b0}}};
  localparam logic [EW-1:0] CLR_WORD = {{(EW-R_LO-PW){1'b0}}, NO_PAR, {R_LO{1'b0}}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FRD  = 3'd3;
  localparam logic [2:0] S_FWR  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [2:0] P_ALLOC = 3'd0;
  localparam logic [2:0] P_KILL  = 3'd1;
  localparam logic [2:0] P_WAKE  = 3'd2;
  localparam logic [2:0] P_REPAR = 3'd3;
  localparam logic [2:0] P_WAIT  = 3'd4;
  localparam logic [2:0] P_SCHED = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [2:0]           pass_r, pass_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 pv_r, pv_nxt;
  logic [SW-1:0]        paddr_r, paddr_nxt;
  logic [3:0]           cmd_r, cmd_nxt;
  logic [5:0]           slot_r, slot_nxt;
  logic [PW-1:0]        apar_r, apar_nxt;
  logic [CHAN_BITS-1:0] ch_r, ch_nxt;
  logic [ID_W-1:0]      tpid_r, tpid_nxt;
  logic                 wtag_r, wtag_nxt;
  logic [CHAN_BITS-1:0] wchan_r, wchan_nxt;
  logic                 wstage_r, wstage_nxt;
  logic                 zflag_r, zflag_nxt;
  logic                 kids_r, kids_nxt;
  logic                 killed_r, killed_nxt;
  logic [ID_W-1:0]      nid_r, nid_nxt;
  logic [SW-1:0]        cur_r, cur_nxt;
  logic [5:0]           init_r;
  logic [1:0]           res_st_r, res_st_nxt;
  logic [SW-1:0]        res_slot_r, res_slot_nxt;
  logic [ID_W-1:0]      res_pid_r, res_pid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [5:0]           out_slot_r, out_slot_nxt;
  logic [ID_W-1:0]      out_pid_r, out_pid_nxt;

  logic                 we;
  logic [SW-1:0]        waddr, raddr;
  logic [EW-1:0]        wdata, rdata, wd;
  logic [2:0]           rd_life;
  logic [PW-1:0]        rd_par, s_par, init_par;
  logic [SW-1:0]        s_ref, init_ref;
  logic                 init_ok, in_ok;
  logic [AW2-1:0]       sum;
  logic [SW-1:0]        scan_addr;
  logic                 hit;

  pts_mem #(.W(EW), .DEPTH(SLOTS), .AW(SW), .RESET_WORD(CLR_WORD)) u_mem (
    .clk(clk), .rst_n(rst_n), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign rd_life  = rdata[L_LO +: 3];
  assign rd_par   = rdata[R_LO +: PW];
  assign s_ref    = SW'(slot_r);
  assign s_par    = {1'b0, s_ref};
  assign init_ref = SW'(init_r);
  assign init_par = {1'b0, init_ref};
  assign init_ok  = {3'b0, init_r} < 9'(SLOTS);
  assign in_ok    = {3'b0, in_slot} < 9'(SLOTS);
  assign sum      = AW2'({{(AW2-SW){1'b0}}, (pass_r == P_SCHED) ? cur_r : {SW{1'b0}}})
                  + AW2'({1'b0, cnt_r});
  assign scan_addr = (sum >= AW2'(SLOTS)) ? SW'(sum - AW2'(SLOTS)) : SW'(sum);

  assign in_ready   = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_pid    = out_pid_r;

  always_comb begin
    state_nxt = state_r; pass_nxt = pass_r; cnt_nxt = cnt_r; pv_nxt = pv_r;
    paddr_nxt = paddr_r; cmd_nxt = cmd_r; slot_nxt = slot_r; apar_nxt = apar_r;
    ch_nxt = ch_r; tpid_nxt = tpid_r; wtag_nxt = wtag_r; wchan_nxt = wchan_r;
    wstage_nxt = wstage_r; zflag_nxt = zflag_r; kids_nxt = kids_r;
    killed_nxt = killed_r; nid_nxt = nid_r; cur_nxt = cur_r;
    res_st_nxt = res_st_r; res_slot_nxt = res_slot_r; res_pid_nxt = res_pid_r;
    out_valid_nxt = out_valid_r; out_status_nxt = out_status_r;
    out_slot_nxt = out_slot_r; out_pid_nxt = out_pid_r;
    we = 1'b0; waddr = paddr_r; wd = rdata; raddr = '0; hit = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        raddr = SW'(in_slot);
        if (in_valid) begin
          cmd_nxt = in_command; slot_nxt = in_slot;
          apar_nxt = (in_has_parent && {3'b0, in_parent_slot} < 9'(SLOTS))
                   ? {1'b0, SW'(in_parent_slot)} : NO_PAR;
          ch_nxt = CHAN_BITS'(in_chan); tpid_nxt = in_target_pid;
          res_st_nxt = STS_FAIL; res_slot_nxt = '0; res_pid_nxt = '0;
          cnt_nxt = '0; pv_nxt = 1'b0; state_nxt = S_OUT;
          case (in_command)
            CMD_ALLOC: begin pass_nxt = P_ALLOC; state_nxt = S_SCAN; end
            CMD_FREE: begin
              if (in_ok) begin
                we = 1'b1; waddr = SW'(in_slot); wd = CLR_WORD; res_st_nxt = STS_DONE;
              end
            end
            CMD_RUNNABLE, CMD_SLEEP, CMD_EXIT, CMD_WAIT, CMD_YIELD: begin
              if (in_ok) state_nxt = S_CHK;
            end
            CMD_WAKEUP: begin
              pass_nxt = P_WAKE; wtag_nxt = 1'b0; wchan_nxt = CHAN_BITS'(in_chan);
              state_nxt = S_SCAN;
            end
            CMD_KILL: begin pass_nxt = P_KILL; state_nxt = S_SCAN; end
            CMD_SCHED: begin pass_nxt = P_SCHED; state_nxt = S_SCAN; end
            default: state_nxt = S_OUT;
          endcase
        end
      end

      S_CHK: begin
        waddr = s_ref; state_nxt = S_OUT;
        case (cmd_r)
          CMD_RUNNABLE: begin
            if (rd_life == LS_EMBRYO) begin
              we = 1'b1; wd[L_LO +: 3] = LS_RUNNABLE; res_st_nxt = STS_DONE;
            end
          end
          CMD_SLEEP: begin
            if (rd_life == LS_RUNNING) begin
              we = 1'b1; wd[L_LO +: 3] = LS_SLEEPING; wd[T_B] = 1'b0;
              wd[C_LO +: CHAN_BITS] = ch_r; res_st_nxt = STS_DONE;
            end
          end
          CMD_YIELD: begin
            if (rd_life == LS_RUNNING) begin
              we = 1'b1; wd[L_LO +: 3] = LS_RUNNABLE; res_st_nxt = STS_DONE;
            end
          end
          CMD_EXIT: begin
            if (rd_life != LS_RUNNING) begin
              res_st_nxt = STS_FAIL;
            end else if (slot_r == init_r) begin
              res_st_nxt = STS_REFUSED;
            end else begin
              // wake the parent first, then hand children to init
              zflag_nxt = 1'b0; cnt_nxt = '0; pv_nxt = 1'b0; state_nxt = S_SCAN;
              if (!rd_par[PW-1]) begin
                pass_nxt = P_WAKE; wtag_nxt = 1'b1; wstage_nxt = 1'b0;
                wchan_nxt = CHAN_BITS'(rd_par[SW-1:0]);
              end else begin
                pass_nxt = P_REPAR;
              end
            end
          end
          CMD_WAIT: begin
            if (rd_life == LS_RUNNING) begin
              killed_nxt = rdata[K_B]; kids_nxt = 1'b0; pass_nxt = P_WAIT;
              cnt_nxt = '0; pv_nxt = 1'b0; state_nxt = S_SCAN;
            end
          end
          default: res_st_nxt = STS_FAIL;
        endcase
      end

      S_SCAN: begin
        if (cnt_r < CW'(SLOTS)) begin
          raddr = scan_addr; cnt_nxt = cnt_r + 1'b1; pv_nxt = 1'b1; paddr_nxt = scan_addr;
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          unique case (pass_r)
            P_ALLOC: begin
              if (rd_life == LS_UNUSED) begin
                we = 1'b1; wd = CLR_WORD; wd[L_LO +: 3] = LS_EMBRYO;
                wd[P_LO +: ID_W] = nid_r; wd[R_LO +: PW] = apar_r;
                nid_nxt = (nid_r == ID_MAX) ? ID_W'(1) : nid_r + 1'b1;
                res_slot_nxt = paddr_r; res_pid_nxt = nid_r; hit = 1'b1;
              end
            end
            P_KILL: begin
              if (rd_life != LS_UNUSED && rdata[P_LO +: ID_W] == tpid_r) begin
                we = 1'b1; wd[K_B] = 1'b1;
                if (rd_life == LS_SLEEPING) wd[L_LO +: 3] = LS_RUNNABLE;
                hit = 1'b1;
              end
            end
            P_WAKE: begin
              if (rd_life == LS_SLEEPING && rdata[T_B] == wtag_r
                  && rdata[C_LO +: CHAN_BITS] == wchan_r) begin
                we = 1'b1; wd[L_LO +: 3] = LS_RUNNABLE;
              end
            end
            P_REPAR: begin
              if (rd_par == s_par) begin
                we = 1'b1; wd[R_LO +: PW] = init_ok ? init_par : NO_PAR;
                if (rd_life == LS_ZOMBIE && init_ok) zflag_nxt = 1'b1;
              end
            end
            P_WAIT: begin
              if (rd_par == s_par) begin
                kids_nxt = 1'b1;
                if (rd_life == LS_ZOMBIE) begin
                  we = 1'b1; wd = CLR_WORD; res_slot_nxt = paddr_r;
                  res_pid_nxt = rdata[P_LO +: ID_W]; hit = 1'b1;
                end
              end
            end
            P_SCHED: begin
              if (rd_life == LS_RUNNABLE) begin
                we = 1'b1; wd[L_LO +: 3] = LS_RUNNING; res_slot_nxt = paddr_r;
                cur_nxt = (paddr_r == SW'(SLOTS - 1)) ? '0 : paddr_r + 1'b1;
                hit = 1'b1;
              end
            end
            default: ;
          endcase
        end
        if (hit) begin
          res_st_nxt = STS_DONE; pv_nxt = 1'b0; state_nxt = S_OUT;
        end else if (!pv_r && cnt_r == CW'(SLOTS)) begin
          cnt_nxt = '0; pv_nxt = 1'b0;
          unique case (pass_r)
            P_WAKE: begin
              if (cmd_r == CMD_WAKEUP) begin
                res_st_nxt = STS_DONE; state_nxt = S_OUT;
              end else if (!wstage_r) begin
                pass_nxt = P_REPAR;
              end else begin
                state_nxt = S_FRD;
              end
            end
            P_REPAR: begin
              if (zflag_r) begin
                pass_nxt = P_WAKE; wtag_nxt = 1'b1; wstage_nxt = 1'b1;
                wchan_nxt = CHAN_BITS'(init_ref);
              end else begin
                state_nxt = S_FRD;
              end
            end
            P_WAIT: begin
              if (!kids_r || killed_r) state_nxt = S_OUT;
              else state_nxt = S_FRD;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end

      S_FRD: begin
        raddr = s_ref; state_nxt = S_FWR;
      end

      S_FWR: begin
        we = 1'b1; waddr = s_ref; state_nxt = S_OUT;
        if (cmd_r == CMD_EXIT) begin
          wd[L_LO +: 3] = LS_ZOMBIE; res_st_nxt = STS_DONE;
        end else begin
          wd[L_LO +: 3] = LS_SLEEPING; wd[T_B] = 1'b1;
          wd[C_LO +: CHAN_BITS] = CHAN_BITS'(s_ref); res_st_nxt = STS_SLEPT;
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1; out_status_nxt = res_st_r;
          out_slot_nxt = 6'(res_slot_r); out_pid_nxt = res_pid_r;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
    wdata = wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; pv_r <= 1'b0; cnt_r <= '0; nid_r <= ID_W'(1);
      cur_r <= '0; init_r <= '0; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; pv_r <= pv_nxt; cnt_r <= cnt_nxt; nid_r <= nid_nxt;
      cur_r <= cur_nxt; out_valid_r <= out_valid_nxt;
      if (cfg_valid) init_r <= cfg_init_slot;
    end
  end

  always_ff @(posedge clk) begin
    pass_r <= pass_nxt; paddr_r <= paddr_nxt; cmd_r <= cmd_nxt; slot_r <= slot_nxt;
    apar_r <= apar_nxt; ch_r <= ch_nxt; tpid_r <= tpid_nxt; wtag_r <= wtag_nxt;
    wchan_r <= wchan_nxt; wstage_r <= wstage_nxt; zflag_r <= zflag_nxt;
    kids_r <= kids_nxt; killed_r <= killed_nxt; res_st_r <= res_st_nxt;
    res_slot_r <= res_slot_nxt; res_pid_r <= res_pid_nxt;
    out_status_r <= out_status_nxt; out_slot_r <= out_slot_nxt; out_pid_r <= out_pid_nxt;
  end

endmodule

`default_nettype wire

// ----- verif/process_table_scheduler_test.sv -----
// ----------------------------------------------------------------------------
// process_table_scheduler_test: self-checking bench for the process table
// A directed table covering extremes and error codes, followed by random
// command streams built mostly from legal life-state sequences. Every command
// is run through a local table model, and each result transfer is compared
// field by field. The run uses several init slot settings and several idling
// phases, and includes one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module process_table_scheduler_test;
  import pts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 64;
  localparam logic [6:0] NO_PAR = 7'h40;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 3 * NSLOT + 40;
  localparam int PHASE_ITEMS = 160;

  typedef struct packed {
    logic [1:0]      status;
    logic [5:0]      slot;
    logic [ID_W-1:0] pid;
  } result_t;

  typedef struct packed {
    logic [3:0]      command;
    logic [5:0]      slot;
    logic [5:0]      parent_slot;
    logic            has_parent;
    logic [31:0]     chan;
    logic [ID_W-1:0] target_pid;
    logic            typed;
    result_t         exp;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [3:0] in_command;
  logic [5:0] in_slot, in_parent_slot;
  logic in_has_parent;
  logic [31:0] in_chan;
  logic [ID_W-1:0] in_target_pid;
  logic out_valid, out_ready;
  logic [1:0] out_status;
  logic [5:0] out_slot;
  logic [ID_W-1:0] out_pid;
  logic cfg_valid, cfg_ready;
  logic [5:0] cfg_init_slot;

  // table model state
  logic [2:0]      life [NSLOT];
  logic [ID_W-1:0] pid_of [NSLOT];
  logic [6:0]      parent_of [NSLOT];
  logic            killed [NSLOT];
  logic [32:0]     wait_chan [NSLOT];
  logic [ID_W-1:0] next_pid;
  logic [5:0]      cursor;
  logic [5:0]      init_slot;

  result_t pending_results[$];
  int fail_count = 0;
  int item_count = 0;
  int result_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_left = 0;

  process_table_scheduler u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_slot(in_slot),
    .in_parent_slot(in_parent_slot), .in_has_parent(in_has_parent),
    .in_chan(in_chan), .in_target_pid(in_target_pid),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_slot(out_slot), .out_pid(out_pid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_init_slot(cfg_init_slot)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_entry(int i);
    life[i] = LS_UNUSED;
    pid_of[i] = '0;
    parent_of[i] = NO_PAR;
    killed[i] = 1'b0;
    wait_chan[i] = '0;
  endfunction

  function automatic void wake_sleepers(logic [32:0] ch);
    for (int i = 0; i < NSLOT; i++)
      if (life[i] == LS_SLEEPING && wait_chan[i] == ch) life[i] = LS_RUNNABLE;
  endfunction

  function automatic void reset_table();
    for (int i = 0; i < NSLOT; i++) clear_entry(i);
    next_pid = 1;
    cursor = '0;
    init_slot = '0;
  endfunction

  function automatic result_t run_command(row_t r);
    result_t res;
    logic kids;
    int k;
    res = '{status: STS_FAIL, slot: '0, pid: '0};
    case (r.command)
      CMD_ALLOC: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (life[i] == LS_UNUSED) begin
            clear_entry(i);
            life[i] = LS_EMBRYO;
            pid_of[i] = next_pid;
            parent_of[i] = r.has_parent ? {1'b0, r.parent_slot} : NO_PAR;
            next_pid = next_pid + 1;
            if (next_pid == 0) next_pid = 1;
            res = '{status: STS_DONE, slot: i[5:0], pid: pid_of[i]};
            break;
          end
        end
      end
      CMD_FREE: begin
        clear_entry(r.slot);
        res.status = STS_DONE;
      end
      CMD_RUNNABLE: begin
        if (life[r.slot] == LS_EMBRYO) begin
          life[r.slot] = LS_RUNNABLE;
          res.status = STS_DONE;
        end
      end
      CMD_SLEEP: begin
        if (life[r.slot] == LS_RUNNING) begin
          wait_chan[r.slot] = {1'b0, r.chan};
          life[r.slot] = LS_SLEEPING;
          res.status = STS_DONE;
        end
      end
      CMD_WAKEUP: begin
        wake_sleepers({1'b0, r.chan});
        res.status = STS_DONE;
      end
      CMD_KILL: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (life[i] != LS_UNUSED && pid_of[i] == r.target_pid) begin
            killed[i] = 1'b1;
            if (life[i] == LS_SLEEPING) life[i] = LS_RUNNABLE;
            res.status = STS_DONE;
            break;
          end
        end
      end
      CMD_EXIT: begin
        if (life[r.slot] == LS_RUNNING) begin
          if (r.slot == init_slot) begin
            res.status = STS_REFUSED;
          end else begin
            if (parent_of[r.slot] != NO_PAR) wake_sleepers({1'b1, 25'd0, parent_of[r.slot]});
            for (int i = 0; i < NSLOT; i++) begin
              if (parent_of[i] == {1'b0, r.slot}) begin
                parent_of[i] = {1'b0, init_slot};
                if (life[i] == LS_ZOMBIE) wake_sleepers({1'b1, 26'd0, init_slot});
              end
            end
            life[r.slot] = LS_ZOMBIE;
            res.status = STS_DONE;
          end
        end
      end
      CMD_WAIT: begin
        if (life[r.slot] == LS_RUNNING) begin
          kids = 1'b0;
          for (int i = 0; i < NSLOT; i++) begin
            if (parent_of[i] == {1'b0, r.slot}) begin
              kids = 1'b1;
              if (life[i] == LS_ZOMBIE) begin
                res = '{status: STS_DONE, slot: i[5:0], pid: pid_of[i]};
                clear_entry(i);
                break;
              end
            end
          end
          if (res.status != STS_DONE && kids && !killed[r.slot]) begin
            wait_chan[r.slot] = {1'b1, 26'd0, r.slot};
            life[r.slot] = LS_SLEEPING;
            res.status = STS_SLEPT;
          end
        end
      end
      CMD_YIELD: begin
        if (life[r.slot] == LS_RUNNING) begin
          life[r.slot] = LS_RUNNABLE;
          res.status = STS_DONE;
        end
      end
      CMD_SCHED: begin
        for (int i = 0; i < NSLOT; i++) begin
          k = (cursor + i) % NSLOT;
          if (life[k] == LS_RUNNABLE) begin
            life[k] = LS_RUNNING;
            cursor = k[5:0] + 6'd1;
            res.slot = k[5:0];
            res.status = STS_DONE;
            break;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // result channel: check every transfer against the oldest expectation
  always @(posedge clk) begin
    result_t exp;
    if (rst_n && out_valid && out_ready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: status %0d slot %0d pid %0d",
               out_status, out_slot, out_pid);
        fail_count++;
      end else begin
        exp = pending_results.pop_front();
        if (out_status !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, out_status);
          fail_count++;
        end
        if (out_slot !== exp.slot) begin
          $error("out_slot: expected %0d, got %0d", exp.slot, out_slot);
          fail_count++;
        end
        if (out_pid !== exp.pid) begin
          $error("out_pid: expected %0d, got %0d", exp.pid, out_pid);
          fail_count++;
        end
      end
    end
  end

  // receiver: random stalls, plus a counted hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // watchdog: abort when no channel moves for too long
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_command(row_t r);
    result_t res;
    @(negedge clk);
    in_valid <= 1'b1;
    in_command <= r.command;
    in_slot <= r.slot;
    in_parent_slot <= r.parent_slot;
    in_has_parent <= r.has_parent;
    in_chan <= r.chan;
    in_target_pid <= r.target_pid;
    do @(posedge clk); while (!in_ready);
    res = run_command(r);
    pending_results.push_back(r.typed ? r.exp : res);
    item_count++;
    // idle gap after the transfer
    if ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      while ($urandom_range(99) < tx_idle_pct) @(negedge clk);
    end
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_init_slot(logic [5:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_init_slot <= value;
    do @(posedge clk); while (!cfg_ready);
    init_slot = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [5:0] slot_in(logic [2:0] st, int hit_pct);
    int base;
    base = $urandom_range(NSLOT - 1);
    if ($urandom_range(99) < hit_pct)
      for (int i = 0; i < NSLOT; i++)
        if (life[(base + i) % NSLOT] == st) return 6'((base + i) % NSLOT);
    return 6'(base);
  endfunction

  function automatic row_t random_command();
    row_t r;
    int pick;
    r = '0;
    r.slot = 6'($urandom_range(NSLOT - 1));
    r.parent_slot = 6'($urandom_range(NSLOT - 1));
    r.has_parent = ($urandom_range(99) < 80);
    r.chan = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(3));
    r.target_pid = ID_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 15) begin
      r.command = CMD_ALLOC;
      r.parent_slot = slot_in(LS_RUNNING, 70);
    end else if (pick < 22) begin
      r.command = CMD_FREE;
      r.slot = slot_in(LS_ZOMBIE, 50);
    end else if (pick < 34) begin
      r.command = CMD_RUNNABLE;
      r.slot = slot_in(LS_EMBRYO, 85);
    end else if (pick < 41) begin
      r.command = CMD_SLEEP;
      r.slot = slot_in(LS_RUNNING, 85);
    end else if (pick < 48) begin
      r.command = CMD_WAKEUP;
    end else if (pick < 54) begin
      r.command = CMD_KILL;
      if ($urandom_range(99) < 70) r.target_pid = pid_of[$urandom_range(NSLOT - 1)];
    end else if (pick < 64) begin
      r.command = CMD_EXIT;
      r.slot = slot_in(LS_RUNNING, 85);
    end else if (pick < 74) begin
      r.command = CMD_WAIT;
      r.slot = slot_in(LS_RUNNING, 85);
    end else if (pick < 81) begin
      r.command = CMD_YIELD;
      r.slot = slot_in(LS_RUNNING, 85);
    end else if (pick < 97) begin
      r.command = CMD_SCHED;
    end else begin
      r.command = 4'($urandom_range(15, 10));
    end
    return r;
  endfunction

  function automatic row_t mk(logic [3:0] c, logic [5:0] s, logic [5:0] ps, logic hp,
                              logic [31:0] ch, logic [ID_W-1:0] tp);
    row_t r;
    r = '0;
    r.command = c; r.slot = s; r.parent_slot = ps; r.has_parent = hp;
    r.chan = ch; r.target_pid = tp;
    return r;
  endfunction

  function automatic row_t mkx(row_t r, logic [1:0] st, logic [5:0] s, logic [ID_W-1:0] p);
    r.typed = 1'b1;
    r.exp = '{status: st, slot: s, pid: p};
    return r;
  endfunction

  initial begin
    row_t directed[$];
    logic [5:0] phase_init [4];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = '0; in_slot = '0; in_parent_slot = '0; in_has_parent = 1'b0;
    in_chan = '0; in_target_pid = '0;
    cfg_valid = 1'b0;
    cfg_init_slot = '0;
    reset_table();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed = '{
      mkx(mk(CMD_SCHED, 0, 0, 0, 0, 0), STS_FAIL, 0, 0),
      mkx(mk(CMD_ALLOC, 0, 0, 0, 0, 0), STS_DONE, 0, 1),
      mkx(mk(CMD_ALLOC, 0, 0, 1, 0, 0), STS_DONE, 1, 2),
      mkx(mk(CMD_ALLOC, 0, 63, 1, 0, 0), STS_DONE, 2, 3),
      mk(CMD_RUNNABLE, 0, 0, 0, 0, 0),
      mkx(mk(CMD_RUNNABLE, 0, 0, 0, 0, 0), STS_FAIL, 0, 0),
      mkx(mk(CMD_EXIT, 0, 0, 0, 0, 0), STS_FAIL, 0, 0),
      mk(CMD_SCHED, 0, 0, 0, 0, 0),
      mkx(mk(CMD_EXIT, 0, 0, 0, 0, 0), STS_REFUSED, 0, 0),
      mk(CMD_RUNNABLE, 1, 0, 0, 0, 0),
      mk(CMD_SCHED, 0, 0, 0, 0, 0),
      mk(CMD_SLEEP, 1, 0, 0, 32'hFFFF_FFFF, 0),
      mk(CMD_WAKEUP, 0, 0, 0, 32'hFFFF_FFFF, 0),
      mk(CMD_SCHED, 0, 0, 0, 0, 0),
      mk(CMD_WAIT, 0, 0, 0, 0, 0),
      mk(CMD_EXIT, 1, 0, 0, 0, 0),
      mk(CMD_SCHED, 0, 0, 0, 0, 0),
      mk(CMD_WAIT, 0, 0, 0, 0, 0),
      mk(CMD_KILL, 0, 0, 0, 0, 3),
      mkx(mk(CMD_KILL, 0, 0, 0, 0, ID_MAX), STS_FAIL, 0, 0),
      mkx(mk(4'd15, 63, 63, 1, 32'hFFFF_FFFF, ID_MAX), STS_FAIL, 0, 0),
      mkx(mk(4'd10, 0, 0, 0, 0, 0), STS_FAIL, 0, 0),
      mk(CMD_YIELD, 0, 0, 0, 0, 0),
      mkx(mk(CMD_FREE, 63, 0, 0, 0, 0), STS_DONE, 0, 0),
      mkx(mk(CMD_WAIT, 2, 0, 0, 0, 0), STS_FAIL, 0, 0)
    };

    write_init_slot(6'd0);
    foreach (directed[i]) send_command(directed[i]);
    drain_and_settle();

    phase_init = '{6'd0, 6'd63, 6'd1, 6'($urandom_range(NSLOT - 1))};
    for (int ph = 0; ph < 4; ph++) begin
      write_init_slot(phase_init[ph]);
      tx_idle_pct = (ph == 1) ? 80 : (ph == 3) ? 33 : 0;
      rx_stall_pct = (ph == 2) ? 80 : (ph == 3) ? 33 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off the receiver so the block backs up into its input
        if (ph == 0 && n == 40) hold_left = 600;
        send_command(random_command());
      end
      drain_and_settle();
    end

    $display("covered %0d commands and %0d results over four init slot settings,",
             item_count, result_count);
    $display("with idle, stall and hold-off phases on both channels");
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
